[rtl/lvsa_pkg.sv]
// Shared constants and helpers for the limb vector to spherical angles unit.
// Holds datapath widths, the CORDIC arctangent table and the angle offsets.
// No dependencies.
`timescale 1ns / 1ps

package lvsa_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_W           = 16;

  // Working width of the vectoring datapaths; scaled differences use 45 bits.
  localparam int WORK_W = 50;
  // Width of a Q.20 angle accumulator.
  localparam int ZW     = 24;

  localparam logic signed [ZW-1:0] PI_Q20      = ZW'(3294199);
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = ZW'(1647099);
  localparam logic [16:0]          INV_GAIN_Q16 = 17'd39797;

  localparam logic [ANGLE_W-1:0] OFS_ELBOW     = 16'd6431;
  localparam logic [ANGLE_W-1:0] OFS_LSHOULDER = 16'd12861;
  localparam logic [ANGLE_W-1:0] ONE_RAD       = 16'd4096;

  localparam logic [1:0] SEG_LEFT_SHOULDER = 2'd2;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(823550);
      1:  a = ZW'(486170);
      2:  a = ZW'(256879);
      3:  a = ZW'(130396);
      4:  a = ZW'(65451);
      5:  a = ZW'(32757);
      6:  a = ZW'(16383);
      7:  a = ZW'(8192);
      8:  a = ZW'(4096);
      9:  a = ZW'(2048);
      10: a = ZW'(1024);
      11: a = ZW'(512);
      12: a = ZW'(256);
      13: a = ZW'(128);
      14: a = ZW'(64);
      15: a = ZW'(32);
      16: a = ZW'(16);
      17: a = ZW'(8);
      18: a = ZW'(4);
      19: a = ZW'(2);
      20: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q.20 radians to Q4.12 with rounding half up.
  function automatic logic [ANGLE_W-1:0] to_q12(input logic signed [ZW-1:0] a);
    logic signed [ZW:0] s;
    s = (ZW+1)'(a) + (ZW+1)'(128);
    return ANGLE_W'(s >>> 8);
  endfunction

endpackage

[rtl/limb_vector_to_spherical_angles_unit.sv]
// Top level of the limb vector to spherical angles unit.
// Instantiates lvsa_cordic twice and lvsa_gain once; depends on lvsa_pkg.
`timescale 1ns / 1ps

// The unit takes one arm segment per cycle (two joint positions and a segment
// code) and returns its azimuth and polar angle in Q4.12 radians, plus a flag
// for a zero-length segment, whose polar angle reads 1 rad. The pipeline is
// one difference stage, two vectoring CORDIC
// pipelines of CORDIC_STAGES+1 stages each, a two-stage gain multiplier and an
// output register. Throughput is one request per cycle; the whole pipeline
// holds while a finished result is not taken.
module limb_vector_to_spherical_angles_unit #(
  parameter int COORD_BITS    = lvsa_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = lvsa_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero padding
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // segment
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // azimuth, polar
  output logic [31:0] out_tdata,
  // degenerate
  output logic [0:0] out_tuser
);

  localparam int W     = lvsa_pkg::WORK_W;
  localparam int ZW    = lvsa_pkg::ZW;
  localparam int AW    = lvsa_pkg::ANGLE_W;
  localparam int DW    = COORD_BITS + 1;
  localparam int SHIFT = 44 - COORD_BITS;
  localparam int SBA   = 3 + W;
  localparam int SBB   = 3 + AW;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey, ez;
  assign sx = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign sy = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign sz = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign ex = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign ey = in_tdata[4*COORD_BITS +: COORD_BITS];
  assign ez = in_tdata[5*COORD_BITS +: COORD_BITS];

  logic                 d_v_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [1:0]           seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DW'(ex) - DW'(sx);
      dy_r  <= DW'(ey) - DW'(sy);
      dz_r  <= DW'(ez) - DW'(sz);
      seg_r <= in_tuser;
    end
  end

  logic signed [W-1:0] dxs, dys, dzs;
  logic                degen;
  assign dxs   = W'(dx_r) <<< SHIFT;
  assign dys   = W'(dy_r) <<< SHIFT;
  assign dzs   = W'(dz_r) <<< SHIFT;
  assign degen = (dx_r == 0) && (dy_r == 0) && (dz_r == 0);

  // Horizontal CORDIC: theta and the raw horizontal length.
  logic                 a_v, a_spec;
  logic signed [ZW-1:0] a_ang;
  logic signed [W-1:0]  a_x, a_slen;
  logic [SBA-1:0]       a_sb;

  lvsa_cordic #(.N(CORDIC_STAGES), .SBW(SBA)) u_cordic_h (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(d_v_r), .in_x(dxs), .in_y(dys), .in_sb({seg_r, degen, dzs}),
    .out_v(a_v), .out_ang(a_ang), .out_x(a_x), .out_spec(a_spec),
    .out_slen(a_slen), .out_sb(a_sb)
  );

  logic                 g_v;
  logic signed [W-1:0]  rho;
  logic signed [ZW-1:0] g_ang;
  logic [SBA-1:0]       g_sb;

  lvsa_gain #(.SBW(SBA)) u_gain (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(a_v), .in_x(a_x), .in_spec(a_spec), .in_slen(a_slen),
    .in_ang(a_ang), .in_sb(a_sb),
    .out_v(g_v), .out_len(rho), .out_ang(g_ang), .out_sb(g_sb)
  );

  // The low segment bit marks an elbow.
  logic [AW-1:0] az;
  assign az = lvsa_pkg::to_q12(g_ang) + (g_sb[W+1] ? lvsa_pkg::OFS_ELBOW : '0);

  // Polar CORDIC: atan2(rho, dz).
  logic                 b_v, b_spec_unused;
  logic signed [ZW-1:0] b_ang;
  logic signed [W-1:0]  b_x_unused, b_slen_unused;
  logic [SBB-1:0]       b_sb;

  lvsa_cordic #(.N(CORDIC_STAGES), .SBW(SBB)) u_cordic_p (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(g_v), .in_x(g_sb[W-1:0]), .in_y(rho), .in_sb({g_sb[W+2:W], az}),
    .out_v(b_v), .out_ang(b_ang), .out_x(b_x_unused), .out_spec(b_spec_unused),
    .out_slen(b_slen_unused), .out_sb(b_sb)
  );

  logic [1:0]    b_seg;
  logic          b_degen;
  logic [AW-1:0] po;
  assign b_seg   = b_sb[AW+2:AW+1];
  assign b_degen = b_sb[AW];
  assign po = b_degen ? lvsa_pkg::ONE_RAD :
              lvsa_pkg::to_q12(b_ang) +
              ((b_seg == lvsa_pkg::SEG_LEFT_SHOULDER) ? lvsa_pkg::OFS_LSHOULDER : '0);

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {po, b_sb[AW-1:0]};
      out_tuser_r <= b_degen;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_degen_polar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[31:16] == lvsa_pkg::ONE_RAD)
    else $error("degenerate result without 1 rad polar angle");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(b_v) && $stable(d_v_r))
    else $error("pipeline moved during a stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");
`endif

endmodule

[rtl/lvsa_cordic.sv]
// Pipelined vectoring CORDIC: one register stage for the half-plane fold,
// then one stage per iteration. Depends on lvsa_pkg.
`timescale 1ns / 1ps

module lvsa_cordic #(
  parameter int N   = lvsa_pkg::CORDIC_STAGES_DEF,
  parameter int SBW = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic signed [lvsa_pkg::WORK_W-1:0]  in_x,
  input  logic signed [lvsa_pkg::WORK_W-1:0]  in_y,
  input  logic [SBW-1:0]                      in_sb,
  output logic                                out_v,
  output logic signed [lvsa_pkg::ZW-1:0]      out_ang,
  output logic signed [lvsa_pkg::WORK_W-1:0]  out_x,
  output logic                                out_spec,
  output logic signed [lvsa_pkg::WORK_W-1:0]  out_slen,
  output logic [SBW-1:0]                      out_sb
);

  localparam int W  = lvsa_pkg::WORK_W;
  localparam int ZW = lvsa_pkg::ZW;

  logic                v_r    [0:N];
  logic signed [W-1:0] x_r    [0:N];
  logic signed [W-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r   [0:N];
  logic                sp_r   [0:N];
  logic                pi_r   [0:N];
  logic signed [W-1:0] sl_r   [0:N];
  logic [SBW-1:0]      sb_r   [0:N];

  logic signed [W-1:0]  x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  // Fold the left half-plane into the right one by a quarter turn.
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        z0_nxt = lvsa_pkg::HALF_PI_Q20;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        z0_nxt = -lvsa_pkg::HALF_PI_Q20;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0_nxt;
      y_r[0]  <= y0_nxt;
      z_r[0]  <= z0_nxt;
      sp_r[0] <= (in_y == 0);
      pi_r[0] <= (in_y == 0) && (in_x < 0);
      sl_r[0] <= (in_x < 0) ? -in_x : in_x;
      sb_r[0] <= in_sb;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    logic signed [W-1:0] xs, ys;
    assign xs = x_r[k-1] >>> (k-1);
    assign ys = y_r[k-1] >>> (k-1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] + ys;
          y_r[k] <= y_r[k-1] - xs;
          z_r[k] <= z_r[k-1] + lvsa_pkg::atan_q20(k-1);
        end else begin
          x_r[k] <= x_r[k-1] - ys;
          y_r[k] <= y_r[k-1] + xs;
          z_r[k] <= z_r[k-1] - lvsa_pkg::atan_q20(k-1);
        end
        sp_r[k] <= sp_r[k-1];
        pi_r[k] <= pi_r[k-1];
        sl_r[k] <= sl_r[k-1];
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign out_v    = v_r[N];
  assign out_ang  = pi_r[N] ? lvsa_pkg::PI_Q20 : (sp_r[N] ? '0 : z_r[N]);
  assign out_x    = (x_r[N] < 0) ? '0 : x_r[N];
  assign out_spec = sp_r[N];
  assign out_slen = sl_r[N];
  assign out_sb   = sb_r[N];

endmodule

[rtl/lvsa_gain.sv]
// Two-stage CORDIC gain correction: multiply by 1/K in Q16, then round.
// Vectors on the x axis (zero y) bypass the correction. Depends on lvsa_pkg.
`timescale 1ns / 1ps

module lvsa_gain #(
  parameter int SBW = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic signed [lvsa_pkg::WORK_W-1:0]  in_x,
  input  logic                                in_spec,
  input  logic signed [lvsa_pkg::WORK_W-1:0]  in_slen,
  input  logic signed [lvsa_pkg::ZW-1:0]      in_ang,
  input  logic [SBW-1:0]                      in_sb,
  output logic                                out_v,
  output logic signed [lvsa_pkg::WORK_W-1:0]  out_len,
  output logic signed [lvsa_pkg::ZW-1:0]      out_ang,
  output logic [SBW-1:0]                      out_sb
);

  localparam int W  = lvsa_pkg::WORK_W;
  localparam int PW = W + 18;

  logic                 v1_r, v2_r;
  logic signed [PW-1:0] prod_r;
  logic                 spec_r;
  logic signed [W-1:0]  slen_r;
  logic signed [lvsa_pkg::ZW-1:0] ang1_r, ang2_r;
  logic [SBW-1:0]       sb1_r, sb2_r;
  logic signed [W-1:0]  len_r;
  logic signed [PW-1:0] rnd;

  assign rnd = (prod_r + PW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(in_x) * signed'({1'b0, lvsa_pkg::INV_GAIN_Q16});
      spec_r <= in_spec;
      slen_r <= in_slen;
      ang1_r <= in_ang;
      sb1_r  <= in_sb;
      len_r  <= spec_r ? slen_r : W'(rnd);
      ang2_r <= ang1_r;
      sb2_r  <= sb1_r;
    end
  end

  assign out_v   = v2_r;
  assign out_len = len_r;
  assign out_ang = ang2_r;
  assign out_sb  = sb2_r;

endmodule

[bench/tb_top.sv]
// Testbench for limb_vector_to_spherical_angles_unit: random and directed arm segments,
// each checked against a bit-accurate CORDIC predictor of azimuth, polar and degenerate.
// Depends on lvsa_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = 16;
  localparam int STAGES = 16;
  localparam int LAT = 2 * STAGES + 6;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic [1:0] segment;
    logic signed [15:0] sx, sy, sz, ex, ey, ez;
  } segment_req_t;

  typedef struct packed {
    logic [15:0] azimuth;
    logic [15:0] polar;
    logic degenerate;
  } angles_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [95:0] in_tdata;
  logic [1:0] in_tuser;
  logic [31:0] out_tdata;
  logic [0:0] out_tuser;

  segment_req_t pending_reqs[$];
  angles_t expected_angles[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  limb_vector_to_spherical_angles_unit #(.COORD_BITS(CB), .CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic longint atan_entry(int i);
    longint tbl[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? tbl[i] : 0;
  endfunction

  // Vectoring CORDIC: returns atan2(y, x) in Q.20 and the gain-corrected length.
  function automatic longint cordic_atan2(longint x, longint y, output longint len);
    longint z, t, xs, ys;
    z = 0;
    if (y == 0) begin
      len = (x < 0) ? -x : x;
      return (x < 0) ? 3294199 : 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1647099;
      end else begin
        t = x; x = -y; y = t; z = -1647099;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_entry(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_entry(i);
      end
    end
    if (x < 0) x = 0;
    len = (x * 39797 + 32768) >>> 16;
    return z;
  endfunction

  function automatic angles_t predict_angles(segment_req_t r);
    angles_t a;
    longint dx, dy, dz, rho, dummy, az, po;
    dx = longint'(r.ex) - longint'(r.sx);
    dy = longint'(r.ey) - longint'(r.sy);
    dz = longint'(r.ez) - longint'(r.sz);
    a.degenerate = (dx == 0 && dy == 0 && dz == 0);
    az = (cordic_atan2(dx <<< (44 - CB), dy <<< (44 - CB), rho) + 128) >>> 8;
    if (r.segment[0]) az += 6431;
    if (a.degenerate) begin
      po = 4096;
    end else begin
      po = (cordic_atan2(dz <<< (44 - CB), rho, dummy) + 128) >>> 8;
      if (r.segment == lvsa_pkg::SEG_LEFT_SHOULDER) po += 12861;
    end
    a.azimuth = az[15:0];
    a.polar = po[15:0];
    return a;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(int seg, int sx, int sy, int sz, int ex, int ey, int ez);
    segment_req_t r;
    r = '{2'(seg), 16'(sx), 16'(sy), 16'(sz), 16'(ex), 16'(ey), 16'(ez)};
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    segment_req_t r;
    // Directed: zero-length on every segment, axis-aligned vectors, extremes.
    for (int s = 0; s < 4; s++) add_req(s, 5, -7, 9, 5, -7, 9);
    for (int s = 0; s < 4; s++) add_req(s, 0, 0, 0, 100, 0, 0);
    add_req(0, 0, 0, 0, -100, 0, 0);
    add_req(1, 0, 0, 0, 0, 0, 300);
    add_req(2, 0, 0, 0, 0, 0, -300);
    add_req(3, 0, 0, 0, 0, 250, 0);
    add_req(0, 0, 0, 0, 0, -250, 0);
    add_req(1, -16'sd32768, -16'sd32768, -16'sd32768, 32767, 32767, 32767);
    add_req(2, 32767, 32767, 32767, -16'sd32768, -16'sd32768, -16'sd32768);
    add_req(3, 32767, -16'sd32768, 32767, -16'sd32768, 32767, -16'sd32768);
    add_req(0, 0, 0, 0, -1, 1, -1);
    add_req(2, 0, 0, 0, -3, -4, 5);
    add_req(1, 0, 0, 0, 1, -1, 0);
    add_req(3, -1, -1, -1, -1, -1, -1);
    for (int n = 0; n < 800; n++) begin
      r.segment = 2'($urandom_range(0, 3));
      r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
      r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
      if ($urandom_range(0, 19) == 0) {r.ex, r.ey, r.ez} = {r.sx, r.sy, r.sz};
      pending_reqs.push_back(r);
    end
    stim_done = 1;
  end

  // Driver: bursts of requests separated by random gaps, updated on the falling edge.
  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0; out_tready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      // A request that is still waiting stays on the bus unchanged.
      if (!in_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 0;
        end else if (pending_reqs.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
          burst_left--;
          in_tvalid <= 1;
          in_tuser <= pending_reqs[0].segment;
          in_tdata <= {pending_reqs[0].ez, pending_reqs[0].ey, pending_reqs[0].ex,
                       pending_reqs[0].sz, pending_reqs[0].sy, pending_reqs[0].sx};
        end else begin
          in_tvalid <= 0;
        end
      end
      // Receiver stall pattern: long free-running stretches mixed with choppy ones.
      out_tready <= ($time / 2400 % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // The in-handshake is sampled at the rising edge, so the expectation must exist
  // before the result can emerge.
  always @(posedge clk) begin
    angles_t got, exp_a;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_angles.push_back(predict_angles(pending_reqs.pop_front()));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[15:0], out_tdata[31:16], out_tuser[0]};
        if (expected_angles.size() == 0) begin
          $error("unexpected result azimuth=%0d polar=%0d", got.azimuth, got.polar);
          errors++;
        end else begin
          exp_a = expected_angles.pop_front();
          if (got.azimuth !== exp_a.azimuth) begin
            $error("azimuth: expected %0d actual %0d", exp_a.azimuth, got.azimuth);
            errors++;
          end
          if (got.polar !== exp_a.polar) begin
            $error("polar: expected %0d actual %0d", exp_a.polar, got.polar);
            errors++;
          end
          if (got.degenerate !== exp_a.degenerate) begin
            $error("degenerate: expected %0d actual %0d", exp_a.degenerate, got.degenerate);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && pending_reqs.size() == 0 && !in_tvalid
             && expected_angles.size() == 0) && idle_cycles < WATCHDOG)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end else begin
      repeat (LAT + 10) @(posedge clk);
      if (errors == 0 && expected_angles.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end

endmodule
